@@ sv/kex_pkg.sv @@
// Package for the keyed extent table: sizes, field widths, status codes,
// word layouts and the controller/datapath command and status structs.
// No dependencies.
package kex_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  localparam int ID_W     = 32;
  localparam int BOUND_W  = 24;
  localparam int POS_W    = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 3;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_WIDENED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_BAD = 3'd4;

  typedef struct packed {
    logic               cmd;
    logic [ID_W-1:0]    item_id;
    logic [BOUND_W-1:0] range_lo;
    logic [BOUND_W-1:0] range_hi;
    logic [POS_W-1:0]   read_index;
  } req_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [ID_W-1:0]     entry_id;
    logic [BOUND_W-1:0]  entry_lo;
    logic [BOUND_W-1:0]  entry_hi;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_word_t;

  typedef struct packed {
    logic [ID_W-1:0]    key;
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
  } entry_t;

  typedef struct packed {
    logic ready;
    logic srch_rd;
    logic srch_step;
    logic chk_rd;
    logic widen;
    logic drop;
    logic shift_init;
    logic shift_rd;
    logic shift_wr;
    logic insert;
    logic read_rd;
    logic read_ok;
    logic read_bad;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic req_valid;
    logic req_read;
    logic search_open;
    logic match;
    logic full;
    logic shift_more;
    logic read_in;
    logic out_free;
  } dp_stat_t;

endpackage

@@ sv/kex_if.sv @@
// Handshake interfaces for the request and result words of the keyed extent table.
// Depends on kex_pkg for the word layouts.
interface kex_req_if import kex_pkg::*; ();
  logic      valid;
  logic      ready;
  req_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kex_rsp_if import kex_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/kex_ctrl.sv @@
// Controller state machine of the keyed extent table: sequences the binary
// search, the compare, the tail shift, the indexed read and the result hand-off. Depends on kex_pkg.
module kex_ctrl import kex_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRCH   = 4'd1;
  localparam logic [3:0] S_CMP    = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_SHIFT  = 4'd4;
  localparam logic [3:0] S_SHWR   = 4'd5;
  localparam logic [3:0] S_RD     = 4'd6;
  localparam logic [3:0] S_RDWAIT = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (stat.req_valid) begin
          state_next = stat.req_read ? S_RD : S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat.search_open) begin
          cmd.srch_rd = 1'b1;
          state_next  = S_CMP;
        end else begin
          cmd.chk_rd = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CMP: begin
        cmd.srch_step = 1'b1;
        state_next    = S_SRCH;
      end
      S_CHK: begin
        if (stat.match) begin
          cmd.widen  = 1'b1;
          state_next = S_EMIT;
        end else if (stat.full) begin
          cmd.drop   = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SHWR;
        end else begin
          cmd.insert = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHIFT;
      end
      S_RD: begin
        if (stat.read_in) begin
          cmd.read_rd = 1'b1;
          state_next  = S_RDWAIT;
        end else begin
          cmd.read_bad = 1'b1;
          state_next   = S_EMIT;
        end
      end
      S_RDWAIT: begin
        cmd.read_ok = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/kex_datapath.sv @@
// Datapath of the keyed extent table: entry memory, search bounds, shift cursor,
// entry count and the result register. Depends on kex_pkg and kex_if.
module kex_datapath import kex_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  kex_req_if.sink        request,
  kex_rsp_if.source      result,
  input  dp_cmd_t        cmd,
  output dp_stat_t       stat
);

  entry_t mem [TABLE_DEPTH];

  entry_t             rd_entry;
  logic               re;
  logic [ADDR_W-1:0]  raddr;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  entry_t             wdata;

  logic [ID_W-1:0]    id_r;
  logic [BOUND_W-1:0] lo_r;
  logic [BOUND_W-1:0] hi_r;
  logic [POS_W-1:0]   ridx_r;
  logic               cmd_r;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   left;
  logic [CNT_W-1:0]   right;
  logic [CNT_W-1:0]   cursor;
  logic [CNT_W-1:0]   mid_calc;
  logic [ADDR_W-1:0]  mid;
  logic [CNT_W-1:0]   cursor_dec;

  logic [BOUND_W-1:0] wide_lo;
  logic [BOUND_W-1:0] wide_hi;

  rsp_word_t          res;
  rsp_word_t          out_word;
  logic               out_valid;
  logic               take;

  assign take     = cmd.ready && request.valid;
  assign mid_calc = left + ((right - left) >> 1);
  assign cursor_dec = cursor - CNT_W'(1);
  assign wide_lo  = (lo_r < rd_entry.lo) ? lo_r : rd_entry.lo;
  assign wide_hi  = (hi_r > rd_entry.hi) ? hi_r : rd_entry.hi;

  assign request.ready = cmd.ready;
  assign result.valid  = out_valid;
  assign result.data   = out_word;

  assign stat.req_valid   = request.valid;
  assign stat.req_read    = (request.data.cmd == CMD_READ);
  assign stat.search_open = (left < right);
  assign stat.match       = (left < count) && (rd_entry.key == id_r);
  assign stat.full        = (count == CNT_W'(TABLE_DEPTH));
  assign stat.shift_more  = (cursor > left);
  assign stat.read_in     = (32'(ridx_r) < 32'(count)) && (cmd_r == CMD_READ);
  assign stat.out_free    = !out_valid || result.ready;

  always_comb begin
    re    = cmd.srch_rd || cmd.chk_rd || cmd.shift_rd || cmd.read_rd;
    raddr = ADDR_W'(ridx_r);
    if (cmd.srch_rd) begin
      raddr = ADDR_W'(mid_calc);
    end else if (cmd.chk_rd) begin
      raddr = ADDR_W'(left);
    end else if (cmd.shift_rd) begin
      raddr = ADDR_W'(cursor_dec);
    end
    we    = cmd.widen || cmd.shift_wr || cmd.insert;
    waddr = ADDR_W'(left);
    wdata = '{key: id_r, lo: lo_r, hi: hi_r};
    if (cmd.widen) begin
      wdata = '{key: id_r, lo: wide_lo, hi: wide_hi};
    end else if (cmd.shift_wr) begin
      waddr = ADDR_W'(cursor);
      wdata = rd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_entry <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r  <= request.data.cmd;
      id_r   <= request.data.item_id;
      lo_r   <= request.data.range_lo;
      hi_r   <= request.data.range_hi;
      ridx_r <= request.data.read_index;
      left   <= '0;
      right  <= count;
    end
    if (cmd.srch_rd) begin
      mid <= ADDR_W'(mid_calc);
    end
    if (cmd.srch_step) begin
      if (rd_entry.key < id_r) begin
        left <= CNT_W'(mid) + CNT_W'(1);
      end else begin
        right <= CNT_W'(mid);
      end
    end
    if (cmd.shift_init) begin
      cursor <= count;
    end
    if (cmd.shift_wr) begin
      cursor <= cursor_dec;
    end
    if (cmd.widen) begin
      res <= '{status: ST_WIDENED, position: POS_W'(left), entry_id: id_r,
               entry_lo: wide_lo, entry_hi: wide_hi, entry_count: '0};
    end
    if (cmd.drop) begin
      res <= '{status: ST_FULL, default: '0};
    end
    if (cmd.insert) begin
      res <= '{status: ST_INSERTED, position: POS_W'(left), entry_id: id_r,
               entry_lo: lo_r, entry_hi: hi_r, entry_count: '0};
    end
    if (cmd.read_ok) begin
      res <= '{status: ST_READ_OK, position: ridx_r, entry_id: rd_entry.key,
               entry_lo: rd_entry.lo, entry_hi: rd_entry.hi, entry_count: '0};
    end
    if (cmd.read_bad) begin
      res <= '{status: ST_READ_BAD, position: ridx_r, default: '0};
    end
    if (cmd.emit) begin
      out_word <= '{status: res.status, position: res.position, entry_id: res.entry_id,
                    entry_lo: res.entry_lo, entry_hi: res.entry_hi,
                    entry_count: COUNT_W'(count)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.insert) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/keyed_extent_table.sv @@
// Keyed extent table: sorted entries with per-identifier low/high extents.
// A read returns the entry at its index, or a bad status for an out-of-range index;
// an update binary-searches the sorted keys, then widens a matching entry, drops the word
// if the table is full, or shifts the tail up and inserts. One word is in work at a time;
// the next word is accepted in the cycle its result can first be taken, later on a stall.
// Reset (rst, synchronous) empties the table; entries need no clearing pass.
module keyed_extent_table import kex_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  kex_req_if.sink   request,
  kex_rsp_if.source result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  kex_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  kex_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .cmd     (cmd),
    .stat    (stat)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> !request.ready)
    else $error("request accepted while a word is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result.valid || result.ready))
    else $error("pending result overwritten");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.entry_count <= COUNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.status == ST_FULL
      |-> result.data.entry_count == COUNT_W'(TABLE_DEPTH))
    else $error("update dropped while table not full");

endmodule
